/* src/slr_pkg.sv */
// Package for the SIR lattice update unit: word types, sizes, event and state codes.
// Used by sir_lattice_update_step_unit; depends on nothing.
package slr_pkg;

  localparam int MAX_SIDE    = 128;
  localparam int SIDE_W      = 7;               // coordinate bits
  localparam int ADDR_W      = 2 * SIDE_W;      // row*MAX_SIDE + col
  localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
  localparam int CHANCE_BITS = 16;
  localparam int THR_W       = CHANCE_BITS + 1;
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int GSIDE_W     = 8;
  localparam int MODE_W      = 4;
  localparam int PICK_W      = 3;
  localparam int EV_W        = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = THR_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBORHOOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE    = 2'd2;

  localparam logic [MODE_W-1:0]  RST_NEIGHBORHOOD = 4'd4;
  localparam logic [THR_W-1:0]   RST_THRESHOLD    = 17'd54067;
  localparam logic [GSIDE_W-1:0] RST_GRID_SIDE    = 8'd100;

  localparam logic [GSIDE_W-1:0] SIDE_MIN = 8'd2;
  localparam logic [GSIDE_W-1:0] SIDE_MAX = GSIDE_W'(MAX_SIDE);

  // neighbourhood modes
  localparam logic [MODE_W-1:0] MODE_3 = 4'd3;
  localparam logic [MODE_W-1:0] MODE_4 = 4'd4;
  localparam logic [MODE_W-1:0] MODE_6 = 4'd6;
  localparam logic [MODE_W-1:0] MODE_8 = 4'd8;

  // commands
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_INFECT  = 3'd1;
  localparam logic [EV_W-1:0] EV_RECOVER = 3'd2;
  localparam logic [EV_W-1:0] EV_WRITE   = 3'd3;
  localparam logic [EV_W-1:0] EV_INVALID = 3'd4;

  // health states
  localparam logic [1:0] HS_S = 2'd0;
  localparam logic [1:0] HS_I = 2'd1;
  localparam logic [1:0] HS_R = 2'd2;

  typedef struct packed {
    logic                   cmd;
    logic [SIDE_W-1:0]      col;
    logic [SIDE_W-1:0]      row;
    logic [PICK_W-1:0]      neighbor_pick;
    logic [CHANCE_BITS-1:0] chance;
    logic [1:0]             new_state;
  } in_word_t;

  typedef struct packed {
    logic [EV_W-1:0]    event_res;
    logic [ADDR_W-1:0]  target_site;
    logic [COUNT_W-1:0] infected_count;
    logic [COUNT_W-1:0] recovered_count;
  } out_word_t;

endpackage

/* src/sir_lattice_update_step_unit.sv */
// SIR lattice update unit: lattice state memory, neighbour map, update and write-back.
// Depends on slr_pkg.
//
// For an accepted word, the site and its partner are read from the lattice memory
// in the accept cycle; then, once the result register is free or being drained, the
// new state is written back and the result registered. The next word is taken once
// the write-back is done. After reset a clearing pass writes every lattice site to
// susceptible, one site a cycle; no word is accepted during it, though configuration
// writes are. The result register lets a new word in while the previous result still
// waits on the output side.
module sir_lattice_update_step_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [slr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [slr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  slr_pkg::in_word_t                in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output slr_pkg::out_word_t               out_word_o
);
  import slr_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [MODE_W-1:0]  neighborhood_q;
  logic [THR_W-1:0]   threshold_q;
  logic [GSIDE_W-1:0] grid_side_q;

  logic [ADDR_W-1:0]  clr_cnt_q;
  logic [COUNT_W-1:0] inf_q, rec_q, inf_d, rec_d;

  // item held between read and write-back
  logic              cmd_q, ok_q, try_inf_q;
  logic [ADDR_W-1:0] site_q, part_q;
  logic [1:0]        nst_q;

  logic [1:0] lattice [DEPTH];
  logic [1:0] rd_site_q, rd_part_q;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [1:0]        mem_wdata;

  logic      out_valid_q;
  out_word_t out_word_q, res;

  logic accept, finish;

  // ---- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neighborhood_q <= RST_NEIGHBORHOOD;
      threshold_q    <= RST_THRESHOLD;
      grid_side_q    <= RST_GRID_SIDE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NEIGHBORHOOD: neighborhood_q <= cfg_wdata_i[MODE_W-1:0];
        CFG_THRESHOLD:    threshold_q    <= cfg_wdata_i[THR_W-1:0];
        CFG_GRID_SIDE:    grid_side_q    <= cfg_wdata_i[GSIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- neighbour map on the incoming word
  logic [GSIDE_W-1:0] side;
  logic [SIDE_W-1:0]  c, r, up, dn, rt, lf, pr, pc;
  logic               par, mode_ok, on_grid, step_ok;

  always_comb begin
    if (grid_side_q < SIDE_MIN)      side = SIDE_MIN;
    else if (grid_side_q > SIDE_MAX) side = SIDE_MAX;
    else                             side = grid_side_q;

    c   = in_word_i.col;
    r   = in_word_i.row;
    par = r[0];
    up  = (r == '0) ? SIDE_W'(side - 8'd1) : r - 1'b1;
    dn  = ({1'b0, r} + 8'd1 == side) ? '0 : r + 1'b1;
    rt  = ({1'b0, c} + 8'd1 == side) ? '0 : c + 1'b1;
    lf  = (c == '0) ? SIDE_W'(side - 8'd1) : c - 1'b1;

    mode_ok = 1'b1;
    pr      = r;
    pc      = c;
    case (neighborhood_q)
      MODE_3: begin
        case (in_word_i.neighbor_pick)
          3'd0:    pr = up;
          3'd1:    pr = dn;
          default: pc = (c[0] == r[0]) ? rt : lf;
        endcase
      end
      MODE_4: begin
        case (in_word_i.neighbor_pick)
          3'd0:    pc = rt;
          3'd1:    pc = lf;
          3'd2:    pr = dn;
          default: pr = up;
        endcase
      end
      MODE_6: begin
        case (in_word_i.neighbor_pick)
          3'd0:    begin pr = up; pc = par ? rt : c;  end
          3'd1:    pc = rt;
          3'd2:    begin pr = dn; pc = par ? rt : c;  end
          3'd3:    begin pr = dn; pc = par ? c  : lf; end
          3'd4:    pc = lf;
          default: begin pr = up; pc = par ? c  : lf; end
        endcase
      end
      MODE_8: begin
        case (in_word_i.neighbor_pick)
          3'd0:    pr = up;
          3'd1:    begin pr = up; pc = rt; end
          3'd2:    pc = rt;
          3'd3:    begin pr = dn; pc = rt; end
          3'd4:    pr = dn;
          3'd5:    begin pr = dn; pc = lf; end
          3'd6:    pc = lf;
          default: begin pr = up; pc = lf; end
        endcase
      end
      default: mode_ok = 1'b0;
    endcase

    on_grid = ({1'b0, c} < side) && ({1'b0, r} < side);
    step_ok = mode_ok && on_grid && ({1'b0, in_word_i.neighbor_pick} < neighborhood_q);
  end

  // ---- control
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  if (finish) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_word_i.cmd;
      ok_q      <= (in_word_i.cmd == CMD_WRITE) || step_ok;
      try_inf_q <= {1'b0, in_word_i.chance} < threshold_q;
      site_q    <= {r, c};
      part_q    <= {pr, pc};
      nst_q     <= in_word_i.new_state;
    end
  end

  // ---- decision and write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = site_q;
    mem_wdata = nst_q;
    inf_d     = inf_q;
    rec_d     = rec_q;
    res.event_res   = EV_INVALID;
    res.target_site = '0;

    if (!ok_q) begin
      res.event_res = EV_INVALID;
    end else if (cmd_q == CMD_WRITE) begin
      res.event_res   = EV_WRITE;
      res.target_site = site_q;
      mem_we          = 1'b1;
      inf_d = inf_q - COUNT_W'(rd_site_q == HS_I) + COUNT_W'(nst_q == HS_I);
      rec_d = rec_q - COUNT_W'(rd_site_q == HS_R) + COUNT_W'(nst_q == HS_R);
    end else begin
      res.event_res   = EV_NONE;
      res.target_site = part_q;
      if (try_inf_q) begin
        if (rd_part_q == HS_S && rd_site_q == HS_I) begin
          res.event_res = EV_INFECT;
          mem_we        = 1'b1;
          mem_waddr     = part_q;
          mem_wdata     = HS_I;
          inf_d         = inf_q + 1'b1;
        end
      end else if (rd_site_q == HS_I) begin
        res.event_res = EV_RECOVER;
        mem_we        = 1'b1;
        mem_wdata     = HS_R;
        inf_d         = inf_q - 1'b1;
        rec_d         = rec_q + 1'b1;
      end
    end

    if (!finish) mem_we = 1'b0;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = HS_S;
    end

    res.infected_count  = inf_d;
    res.recovered_count = rec_d;
  end

  // ---- lattice memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) lattice[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_site_q <= lattice[{r, c}];
      rd_part_q <= lattice[{pr, pc}];
    end
  end

  // ---- totals and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inf_q       <= '0;
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        inf_q       <= inf_d;
        rec_q       <= rec_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) out_word_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
